// ===== hdl/sal_pkg.sv =====
package sal_pkg;

   // Default list capacity
   localparam int SAL_CAPACITY = 16;

   typedef enum logic [2:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_DELETE   = 3'd1,
      FUNC_LOCATE   = 3'd2,
      FUNC_RETRIEVE = 3'd3,
      FUNC_SORTED   = 3'd4,
      FUNC_CLEAR    = 3'd5
   } sal_func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } sal_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_SCAN,
      S_SORT_SCAN,
      S_FETCH,
      S_PLACE,
      S_DONE
   } sal_state_type;

   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_CNT_M1,
      PTR_ZERO,
      PTR_POS,
      PTR_POS_P1,
      PTR_INC,
      PTR_DEC
   } sal_ptr_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SHIFT_UP,
      WR_SHIFT_DN,
      WR_PLACE
   } sal_wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLEAR
   } sal_cnt_op_type;

   typedef enum logic [1:0] {
      TGT_HOLD,
      TGT_POS,
      TGT_PTR,
      TGT_COUNT
   } sal_tgt_op_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_CLEAR,
      RES_STATUS,
      RES_HIT,
      RES_READ,
      RES_PLACED
   } sal_res_op_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        payload;
   } sal_rec_type;

   typedef struct packed {
      logic           load_op;
      sal_ptr_op_type ptr_op;
      logic           rd_en;
      sal_wr_op_type  wr_op;
      sal_cnt_op_type cnt_op;
      sal_tgt_op_type tgt_op;
      sal_res_op_type res_op;
      sal_status_type res_status;
      logic           load_rsp;
   } sal_cmd_type;

   typedef struct packed {
      sal_func_type func;
      logic         ins_pos_bad;
      logic         pos_bad;
      logic         full;
      logic         empty;
      logic         ins_at_end;
      logic         pos_last;
      logic         ptr_last;
      logic         ptr_at_tgt;
      logic         key_hit;
      logic         key_less;
   } sal_sts_type;

endpackage

// ===== hdl/sal_ctrl.sv =====
module sal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sal_pkg::sal_sts_type sts,
   output sal_pkg::sal_cmd_type cmd
);
   import sal_pkg::*;

   sal_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load_op    = 1'b0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.rd_en      = 1'b0;
      cmd.wr_op      = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.tgt_op     = TGT_HOLD;
      cmd.res_op     = RES_NONE;
      cmd.res_status = ST_OK;
      cmd.load_rsp   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_op = 1'b1;
               cmd.res_op  = RES_CLEAR;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            case (sts.func)
               FUNC_INSERT: begin
                  if (sts.ins_pos_bad) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_BADPOS;
                  end else if (sts.full) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.tgt_op = TGT_POS;
                     if (sts.ins_at_end) begin
                        state_in = S_PLACE;
                     end else begin
                        cmd.ptr_op = PTR_CNT_M1;
                        cmd.rd_en  = 1'b1;
                        state_in   = S_SHIFT_UP;
                     end
                  end
               end
               FUNC_DELETE: begin
                  if (sts.pos_bad) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_BADPOS;
                  end else if (sts.pos_last) begin
                     cmd.cnt_op = CNT_DEC;
                  end else begin
                     cmd.ptr_op = PTR_POS_P1;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_SHIFT_DN;
                  end
               end
               FUNC_LOCATE: begin
                  if (sts.empty) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_NOTFOUND;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_SCAN;
                  end
               end
               FUNC_RETRIEVE: begin
                  if (sts.pos_bad) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_BADPOS;
                  end else begin
                     cmd.ptr_op = PTR_POS;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_FETCH;
                  end
               end
               FUNC_SORTED: begin
                  if (sts.full) begin
                     cmd.res_op     = RES_STATUS;
                     cmd.res_status = ST_FULL;
                  end else if (sts.empty) begin
                     cmd.tgt_op = TGT_COUNT;
                     state_in   = S_PLACE;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                     cmd.rd_en  = 1'b1;
                     state_in   = S_SORT_SCAN;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.cnt_op = CNT_CLEAR;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_SHIFT_UP: begin
            cmd.wr_op = WR_SHIFT_UP;
            if (sts.ptr_at_tgt) begin
               state_in = S_PLACE;
            end else begin
               cmd.ptr_op = PTR_DEC;
               cmd.rd_en  = 1'b1;
            end
         end
         S_SHIFT_DN: begin
            cmd.wr_op = WR_SHIFT_DN;
            if (sts.ptr_last) begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_DONE;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_en  = 1'b1;
            end
         end
         S_SCAN: begin
            if (sts.key_hit) begin
               cmd.res_op = RES_HIT;
               state_in   = S_DONE;
            end else if (sts.ptr_last) begin
               cmd.res_op     = RES_STATUS;
               cmd.res_status = ST_NOTFOUND;
               state_in       = S_DONE;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_en  = 1'b1;
            end
         end
         S_SORT_SCAN: begin
            if (!sts.key_less) begin
               cmd.tgt_op = TGT_PTR;
               cmd.ptr_op = PTR_CNT_M1;
               cmd.rd_en  = 1'b1;
               state_in   = S_SHIFT_UP;
            end else if (sts.ptr_last) begin
               cmd.tgt_op = TGT_COUNT;
               state_in   = S_PLACE;
            end else begin
               cmd.ptr_op = PTR_INC;
               cmd.rd_en  = 1'b1;
            end
         end
         S_FETCH: begin
            cmd.res_op = RES_READ;
            state_in   = S_DONE;
         end
         S_PLACE: begin
            cmd.wr_op  = WR_PLACE;
            cmd.cnt_op = CNT_INC;
            cmd.res_op = RES_PLACED;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

// ===== hdl/sal_dpath.sv =====
module sal_dpath #(
   parameter int CAPACITY = sal_pkg::SAL_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           req_func,
   input  logic [4:0]           req_position,
   input  logic signed [31:0]   req_key,
   input  logic [31:0]          req_payload,
   input  sal_pkg::sal_cmd_type cmd,
   output sal_pkg::sal_sts_type sts,
   output logic [1:0]           rsp_status,
   output logic [4:0]           rsp_found_position,
   output logic signed [31:0]   rsp_key_out,
   output logic [31:0]          rsp_payload_out,
   output logic [4:0]           rsp_entry_count
);
   import sal_pkg::*;

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int CMPW = (CNTW > 5) ? CNTW : 5;

   sal_rec_type    mem [CAPACITY];

   sal_func_type   op_func_ff;
   logic [4:0]     op_pos_ff;
   sal_rec_type    op_rec_ff;
   logic [IW-1:0]  ptr_ff, ptr_in;
   logic [IW-1:0]  tgt_ff, tgt_in;
   logic [CNTW-1:0] count_ff, count_in;
   sal_rec_type    rdata_ff;
   sal_status_type res_status_ff, res_status_in;
   logic [4:0]     res_fpos_ff, res_fpos_in;
   sal_rec_type    res_rec_ff, res_rec_in;

   logic [CMPW-1:0] pos_ext, cnt_ext, ptr_ext, tgt_ext;
   logic [IW-1:0]   pos_idx, cnt_m1_idx;
   logic [CNTW-1:0] cnt_m1;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   sal_rec_type     wr_data;

   assign pos_ext    = CMPW'(op_pos_ff);
   assign cnt_ext    = CMPW'(count_ff);
   assign ptr_ext    = CMPW'(ptr_ff);
   assign tgt_ext    = CMPW'(tgt_ff);
   assign pos_idx    = pos_ext[IW-1:0];
   assign cnt_m1     = count_ff - CNTW'(1);
   assign cnt_m1_idx = cnt_m1[IW-1:0];

   // status towards the controller
   assign sts.func        = op_func_ff;
   assign sts.ins_pos_bad = pos_ext > cnt_ext;
   assign sts.pos_bad     = pos_ext >= cnt_ext;
   assign sts.full        = count_ff == CNTW'(CAPACITY);
   assign sts.empty       = count_ff == '0;
   assign sts.ins_at_end  = pos_ext == cnt_ext;
   assign sts.pos_last    = pos_ext == CMPW'(cnt_m1);
   assign sts.ptr_last    = CNTW'(ptr_ff) == cnt_m1;
   assign sts.ptr_at_tgt  = ptr_ff == tgt_ff;
   assign sts.key_hit     = rdata_ff.key == op_rec_ff.key;
   assign sts.key_less    = $signed(rdata_ff.key) < $signed(op_rec_ff.key);

   always_comb begin
      case (cmd.ptr_op)
         PTR_CNT_M1: ptr_in = cnt_m1_idx;
         PTR_ZERO:   ptr_in = '0;
         PTR_POS:    ptr_in = pos_idx;
         PTR_POS_P1: ptr_in = pos_idx + IW'(1);
         PTR_INC:    ptr_in = ptr_ff + IW'(1);
         PTR_DEC:    ptr_in = ptr_ff - IW'(1);
         default:    ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.tgt_op)
         TGT_POS:   tgt_in = pos_idx;
         TGT_PTR:   tgt_in = ptr_ff;
         TGT_COUNT: tgt_in = count_ff[IW-1:0];
         default:   tgt_in = tgt_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CNTW'(1);
         CNT_DEC:   count_in = count_ff - CNTW'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_data = rdata_ff;
      case (cmd.wr_op)
         WR_SHIFT_UP: wr_addr = ptr_ff + IW'(1);
         WR_SHIFT_DN: wr_addr = ptr_ff - IW'(1);
         WR_PLACE: begin
            wr_addr = tgt_ff;
            wr_data = op_rec_ff;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = ptr_ff;
         end
      endcase
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_fpos_in   = res_fpos_ff;
      res_rec_in    = res_rec_ff;
      case (cmd.res_op)
         RES_CLEAR: begin
            res_status_in = ST_OK;
            res_fpos_in   = '0;
            res_rec_in    = '0;
         end
         RES_STATUS: res_status_in = cmd.res_status;
         RES_HIT: begin
            res_status_in = ST_OK;
            res_fpos_in   = ptr_ext[4:0];
            res_rec_in    = rdata_ff;
         end
         RES_READ:   res_rec_in  = rdata_ff;
         RES_PLACED: res_fpos_in = tgt_ext[4:0];
         default:    res_status_in = res_status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         op_func_ff        <= sal_func_type'(req_func);
         op_pos_ff         <= req_position;
         op_rec_ff.key     <= req_key;
         op_rec_ff.payload <= req_payload;
      end
      ptr_ff        <= ptr_in;
      tgt_ff        <= tgt_in;
      res_status_ff <= res_status_in;
      res_fpos_ff   <= res_fpos_in;
      res_rec_ff    <= res_rec_in;
      if (cmd.load_rsp) begin
         rsp_status         <= res_status_ff;
         rsp_found_position <= res_fpos_ff;
         rsp_key_out        <= res_rec_ff.key;
         rsp_payload_out    <= res_rec_ff.payload;
         rsp_entry_count    <= cnt_ext[4:0];
      end
   end

   // record store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[ptr_in];
      end
   end

endmodule

// ===== hdl/sorted_array_list_engine.sv =====
// Channel  Direction  Handshake              Payload
// req_     in         req_valid / req_ready  func, position, key, payload
// rsp_     out        rsp_valid / rsp_ready  status, found_position, key_out,
//                                            payload_out, entry_count
//
// One item at a time: accept, then decode, then the store is walked one entry per cycle.
// Insert shifts entries up and places the record, sorted insert scans, shifts and places,
// delete shifts entries down, locate scans, retrieve reads one entry, clear and refusals
// only decode; the result is then loaded into the output register once that is free.
// Reset is synchronous and clears the count and the handshake, never the store.
// A stalled result holds in the output register while the next item is worked on.
module sorted_array_list_engine #(
   parameter int CAPACITY = sal_pkg::SAL_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_func,
   input  logic [4:0]          req_position,
   input  logic signed [31:0]  req_key,
   input  logic [31:0]         req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_found_position,
   output logic signed [31:0]  rsp_key_out,
   output logic [31:0]         rsp_payload_out,
   output logic [4:0]          rsp_entry_count
);
   import sal_pkg::*;

   // commands from the sequencer, flags back from the store
   sal_cmd_type cmd;
   sal_sts_type sts;

   // sequencer: decode the operation, step the walk, hand off the result
   sal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // store, count, walk pointer, working result and output register
   sal_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_key_out        (rsp_key_out),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_entry_count    (rsp_entry_count)
   );

endmodule

// ===== hdl/sal_checker.sv =====
module sal_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [2:0]         req_func,
   input logic [4:0]         req_position,
   input logic signed [31:0] req_key,
   input logic [31:0]        req_payload,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_found_position,
   input logic signed [31:0] rsp_key_out,
   input logic [31:0]        rsp_payload_out,
   input logic [4:0]         rsp_entry_count
);
   import sal_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_key_out) && $stable(rsp_payload_out)
         && $stable(rsp_entry_count) && $stable(rsp_found_position))
      else $error("result changed while stalled");

   // one item in flight: ready drops after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in work");

   // refusals carry no record
   a_refusal_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BADPOS || rsp_status == ST_FULL
         || rsp_status == ST_NOTFOUND) |-> rsp_key_out == '0
         && rsp_payload_out == '0 && rsp_found_position == '0)
      else $error("refused operation returned data");

   // nothing to deliver straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind sorted_array_list_engine sal_checker u_sal_checker (.*);

// ===== verif/sorted_array_list_engine_test.sv =====
`timescale 1ns / 1ps

module sorted_array_list_engine_test;

   import sal_pkg::*;

   localparam int CAPACITY = SAL_CAPACITY;

   // Function codes that the block must treat as no operation
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

   // Long receiver hold-off, in cycles, so that the block fills and stalls its input
   localparam int HOLD_OFF_CYCLES = 400;

   // Margin after the last reply, well beyond the longest single operation
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   // One expected reply, at the widths of the result ports
   typedef struct {
      sal_status_type     status;
      logic [4:0]         found_pos;
      logic signed [31:0] key;
      logic [31:0]        payload;
      logic [4:0]         count;
   } list_reply_type;

   // Shadow copy of the record list: works out the reply of each accepted item and
   // holds the replies still owed by the block, oldest first.
   class record_list_checker;
      logic signed [31:0] rec_key [CAPACITY];
      logic [31:0]        rec_payload [CAPACITY];
      int                 held;
      int                 peak;
      int                 errors;
      int                 replies;
      int                 status_seen [4];
      list_reply_type     pending_replies [$];

      function new();
         held    = 0;
         peak    = 0;
         errors  = 0;
         replies = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Open a gap at slot at and write the record there
      function void open_slot(int at, logic signed [31:0] key, logic [31:0] pay);
         for (int slot = held; slot > at; slot--) begin
            rec_key[slot]     = rec_key[slot - 1];
            rec_payload[slot] = rec_payload[slot - 1];
         end
         rec_key[at]     = key;
         rec_payload[at] = pay;
         held++;
         if (held > peak) peak = held;
      endfunction

      function void apply_request(logic [2:0] func, logic [4:0] pos,
                                  logic signed [31:0] key, logic [31:0] pay);
         list_reply_type want;
         int             slot;
         want.status    = ST_OK;
         want.found_pos = '0;
         want.key       = '0;
         want.payload   = '0;
         case (func)
            FUNC_INSERT: begin
               // position is checked before fullness
               if (int'(pos) > held) want.status = ST_BADPOS;
               else if (held >= CAPACITY) want.status = ST_FULL;
               else begin
                  open_slot(int'(pos), key, pay);
                  want.found_pos = pos;
               end
            end
            FUNC_DELETE: begin
               if (int'(pos) >= held) want.status = ST_BADPOS;
               else begin
                  for (slot = int'(pos); slot + 1 < held; slot++) begin
                     rec_key[slot]     = rec_key[slot + 1];
                     rec_payload[slot] = rec_payload[slot + 1];
                  end
                  held--;
               end
            end
            FUNC_LOCATE: begin
               want.status = ST_NOTFOUND;
               for (slot = 0; slot < held; slot++) begin
                  if (rec_key[slot] == key) begin
                     want.status    = ST_OK;
                     want.found_pos = 5'(slot);
                     want.key       = rec_key[slot];
                     want.payload   = rec_payload[slot];
                     break;
                  end
               end
            end
            FUNC_RETRIEVE: begin
               if (int'(pos) >= held) want.status = ST_BADPOS;
               else begin
                  want.key     = rec_key[pos];
                  want.payload = rec_payload[pos];
               end
            end
            FUNC_SORTED: begin
               if (held >= CAPACITY) want.status = ST_FULL;
               else begin
                  // signed order; equal keys go in front of the existing ones
                  slot = 0;
                  while (slot < held && rec_key[slot] < key) slot++;
                  open_slot(slot, key, pay);
                  want.found_pos = 5'(slot);
               end
            end
            FUNC_CLEAR: held = 0;
            default: ;
         endcase
         want.count = 5'(held);
         status_seen[want.status]++;
         pending_replies.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_reply(logic [1:0] status, logic [4:0] found_pos, logic signed [31:0] key,
                       logic [31:0] payload, logic [4:0] count);
         list_reply_type want;
         if (pending_replies.size() == 0) begin
            report_mismatch("reply arrived with no item outstanding");
            return;
         end
         want = pending_replies.pop_front();
         replies++;
         if (status !== want.status)
            report_mismatch($sformatf("reply %0d status: got %0d, expected %0d",
                                      replies, status, want.status));
         if (found_pos !== want.found_pos)
            report_mismatch($sformatf("reply %0d found_position: got %0d, expected %0d",
                                      replies, found_pos, want.found_pos));
         if (key !== want.key)
            report_mismatch($sformatf("reply %0d key_out: got %h, expected %h",
                                      replies, key, want.key));
         if (payload !== want.payload)
            report_mismatch($sformatf("reply %0d payload_out: got %h, expected %h",
                                      replies, payload, want.payload));
         if (count !== want.count)
            report_mismatch($sformatf("reply %0d entry_count: got %0d, expected %0d",
                                      replies, count, want.count));
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [2:0]         req_func;
   logic [4:0]         req_position;
   logic signed [31:0] req_key;
   logic [31:0]        req_payload;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_found_position;
   logic signed [31:0] rsp_key_out;
   logic [31:0]        rsp_payload_out;
   logic [4:0]         rsp_entry_count;

   // Knobs for the stimulus and the receiver, set by the main sequence
   bit send_gaps;
   bit ready_stalls;
   bit hold_request;

   record_list_checker lists;

   sorted_array_list_engine dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_position       (req_position),
      .req_key            (req_key),
      .req_payload        (req_payload),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_key_out        (rsp_key_out),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_entry_count    (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Offer one item: maybe idle first, then drive at the falling edge and hold
   // until the rising edge at which the block takes it.
   task automatic send_request(input logic [2:0] func, input logic [4:0] pos,
                               input logic signed [31:0] key, input logic [31:0] pay);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_func     <= func;
      req_position <= pos;
      req_key      <= key;
      req_payload  <= pay;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      lists.apply_request(func, pos, key, pay);
   endtask

   // Keys lean towards the extremes and a small pool around zero, so that equal
   // keys and locate hits turn up often.
   function automatic logic signed [31:0] random_key();
      case ($urandom_range(0, 9))
         0:          return 32'h8000_0000;
         1:          return 32'h7fff_ffff;
         2, 3, 4, 5: return int'($urandom_range(0, 6)) - 3;
         default:    return $urandom;
      endcase
   endfunction

   // Mostly well-formed items against the current list, with some out-of-range
   // positions and the unused function codes mixed in.
   task automatic send_random();
      logic [2:0]         func;
      logic [4:0]         pos;
      logic signed [31:0] key;
      int                 roll;
      int                 span;
      roll = $urandom_range(0, 99);
      if (roll < 20)      func = FUNC_INSERT;
      else if (roll < 40) func = FUNC_SORTED;
      else if (roll < 62) func = FUNC_DELETE;
      else if (roll < 77) func = FUNC_LOCATE;
      else if (roll < 90) func = FUNC_RETRIEVE;
      else if (roll < 93) func = FUNC_CLEAR;
      else if (roll < 97) func = FUNC_UNUSED_LO;
      else                func = FUNC_UNUSED_HI;
      span = (func == FUNC_INSERT) ? lists.held : lists.held - 1;
      if (span < 0 || $urandom_range(0, 4) == 0) pos = 5'($urandom_range(0, 31));
      else pos = 5'($urandom_range(0, span));
      key = random_key();
      if (func == FUNC_LOCATE && lists.held > 0 && $urandom_range(0, 4) != 0)
         key = lists.rec_key[$urandom_range(0, lists.held - 1)];
      send_request(func, pos, key, $urandom);
   endtask

   // Receiver: drive ready at the falling edge, in random bursts of hold-off,
   // plus one long hold-off on request.
   initial begin
      int idle_left;
      int hold_left;
      bit hold_taken;
      idle_left  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = HOLD_OFF_CYCLES;
            hold_taken = 1'b1;
         end
         if (!ready_stalls) idle_left = 0;
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (ready_stalls && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 19);
         end
      end
   end

   // Check every reply taken at the rising edge
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         lists.check_reply(rsp_status, rsp_found_position, rsp_key_out, rsp_payload_out,
                           rsp_entry_count);
   end

   // Guard against a hung block
   initial begin
      #2_000_000;
      $display("Timed out with replies still outstanding");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      lists        = new();
      send_gaps    = 1'b1;
      ready_stalls = 1'b1;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_CLEAR;
      req_position = '0;
      req_key      = '0;
      req_payload  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty list refusals
      send_request(FUNC_CLEAR, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_RETRIEVE, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_DELETE, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_LOCATE, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_INSERT, 5'd1, 32'sd5, 32'h1111_1111);
      send_request(FUNC_INSERT, 5'd31, 32'sd5, 32'h2222_2222);

      // Build a short list: extreme keys, then equal keys in a sorted insert
      send_request(FUNC_INSERT, 5'd0, 32'h7fff_ffff, 32'hffff_ffff);
      send_request(FUNC_SORTED, 5'd31, 32'h8000_0000, 32'h0000_0000);
      send_request(FUNC_SORTED, 5'd0, 32'sd0, 32'h5a5a_5a5a);
      send_request(FUNC_SORTED, 5'd0, 32'sd0, 32'ha5a5_a5a5);
      send_request(FUNC_INSERT, 5'(lists.held), -32'sd1, 32'h0000_0001);
      send_request(FUNC_INSERT, 5'd2, 32'sd0, 32'h0000_0002);

      // Locate the first of several equal keys, a lone key, and a missing one
      send_request(FUNC_LOCATE, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_LOCATE, 5'd0, -32'sd1, 32'h0);
      send_request(FUNC_LOCATE, 5'd0, 32'sd12345, 32'h0);

      // Retrieve at the last entry, just past it, and at the widest position
      send_request(FUNC_RETRIEVE, 5'(lists.held - 1), 32'sd0, 32'h0);
      send_request(FUNC_RETRIEVE, 5'(lists.held), 32'sd0, 32'h0);
      send_request(FUNC_RETRIEVE, 5'd31, 32'sd0, 32'h0);

      // Delete from the front, from the back, and out of range
      send_request(FUNC_DELETE, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_DELETE, 5'(lists.held - 1), 32'sd0, 32'h0);
      send_request(FUNC_DELETE, 5'd31, 32'sd0, 32'h0);

      // Unused codes leave the list alone; then clear it
      send_request(FUNC_UNUSED_LO, 5'($urandom), random_key(), $urandom);
      send_request(FUNC_UNUSED_HI, 5'($urandom), random_key(), $urandom);
      send_request(FUNC_CLEAR, 5'd0, 32'sd0, 32'h0);
      send_request(FUNC_RETRIEVE, 5'd0, 32'sd0, 32'h0);

      // Fill to capacity with random records, then push against the limit
      while (lists.held < CAPACITY) begin
         if ($urandom_range(0, 1) == 1)
            send_request(FUNC_SORTED, 5'($urandom), random_key(), $urandom);
         else
            send_request(FUNC_INSERT, 5'($urandom_range(0, lists.held)), random_key(), $urandom);
      end
      send_request(FUNC_SORTED, 5'd0, random_key(), $urandom);
      send_request(FUNC_INSERT, 5'(CAPACITY), random_key(), $urandom);
      send_request(FUNC_INSERT, 5'(CAPACITY + 1), random_key(), $urandom);
      send_request(FUNC_RETRIEVE, 5'(CAPACITY - 1), 32'sd0, 32'h0);
      send_request(FUNC_LOCATE, 5'd0, lists.rec_key[CAPACITY - 1], 32'h0);
      send_request(FUNC_DELETE, 5'(CAPACITY - 1), 32'sd0, 32'h0);
      send_request(FUNC_DELETE, 5'd0, 32'sd0, 32'h0);

      // Hold the receiver off for a long stretch while items keep coming
      hold_request = 1'b1;
      repeat (20) send_random();

      // Main random body with idling on both sides
      repeat (300) send_random();

      // Closing stretch at full rate
      send_gaps    = 1'b0;
      ready_stalls = 1'b0;
      repeat (100) send_random();

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then allow for any stray reply
      while (lists.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d replies: %0d ok, %0d bad position, %0d full, %0d key not found",
               lists.replies, lists.status_seen[ST_OK], lists.status_seen[ST_BADPOS],
               lists.status_seen[ST_FULL], lists.status_seen[ST_NOTFOUND]);
      $display("List peaked at %0d of %0d records; %0d mismatches",
               lists.peak, CAPACITY, lists.errors);
      if (lists.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/sal_pkg.sv
hdl/sal_ctrl.sv
hdl/sal_dpath.sv
hdl/sorted_array_list_engine.sv
hdl/sal_checker.sv
verif/sorted_array_list_engine_test.sv
